FILE: src/pmt_pkg.sv
// ----------------------------------------------------------------------------
// Periodic microsecond timer bank package
// Field widths, stream layout, operation codes and the command record that
// passes from the front end to the back end.
// ----------------------------------------------------------------------------
package pmt_pkg;

  localparam int unsigned OP_W   = 2;
  localparam int unsigned SLOT_W = 3;
  localparam int unsigned TIME_W = 32;
  localparam int unsigned CNT_W  = 17;
  localparam int unsigned MASK_W = 8;

  localparam int unsigned IN_OP_LSB     = 0;
  localparam int unsigned IN_SLOT_LSB   = IN_OP_LSB + OP_W;
  localparam int unsigned IN_PERIOD_LSB = IN_SLOT_LSB + SLOT_W;
  localparam int unsigned IN_MS_LSB     = IN_PERIOD_LSB + TIME_W;
  localparam int unsigned IN_CNT_LSB    = IN_MS_LSB + TIME_W;
  localparam int unsigned IN_BITS       = IN_CNT_LSB + CNT_W;
  localparam int unsigned IN_DATA_W     = ((IN_BITS + 7) / 8) * 8;

  localparam int unsigned OUT_BITS   = MASK_W + 1;
  localparam int unsigned OUT_DATA_W = ((OUT_BITS + 7) / 8) * 8;

  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned DIV_STEP    = 8;

  localparam logic [OP_W-1:0] OP_POLL  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_STOP  = 2'd2;

  typedef enum logic [1:0] {
    KIND_POLL   = 2'd0,
    KIND_START  = 2'd1,
    KIND_STOP   = 2'd2,
    KIND_REJECT = 2'd3
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic [SLOT_W-1:0]   slot;
    logic [TIME_W-1:0]   period;
    logic [TIME_W-1:0]   ms;
    logic [CNT_W-1:0]    cnt;
  } cmd_t;

endpackage

FILE: src/pmt_front.sv
// ----------------------------------------------------------------------------
// Timer bank front end
// Accepts input transfers, classifies each operation and holds the
// resulting commands in a short queue for the back end.
// ----------------------------------------------------------------------------
module pmt_front
  import pmt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS = 8
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_valid_i,
  output logic                 s_ready_o,
  input  logic [IN_DATA_W-1:0] s_data_i,
  output logic                 cmd_valid_o,
  input  logic                 cmd_ready_i,
  output cmd_t                 cmd_o
);

  localparam int unsigned QPTR_W = $clog2(QUEUE_DEPTH);
  localparam logic [QPTR_W:0] QFULL = (QPTR_W + 1)'(QUEUE_DEPTH);

  cmd_t              q_mem [QUEUE_DEPTH];
  cmd_t              cmd_new;
  logic [QPTR_W-1:0] wr_ptr_q, rd_ptr_q;
  logic [QPTR_W:0]   count_q, count_d;
  logic [OP_W-1:0]   op;
  logic              slot_ok;
  logic              push, pop;

  always_comb begin
    op             = s_data_i[IN_OP_LSB +: OP_W];
    cmd_new.slot   = s_data_i[IN_SLOT_LSB +: SLOT_W];
    cmd_new.period = s_data_i[IN_PERIOD_LSB +: TIME_W];
    cmd_new.ms     = s_data_i[IN_MS_LSB +: TIME_W];
    cmd_new.cnt    = s_data_i[IN_CNT_LSB +: CNT_W];
    slot_ok        = {29'd0, cmd_new.slot} < 32'(NUM_TIMERS);
    case (op)
      OP_POLL:  cmd_new.kind = KIND_POLL;
      OP_START: cmd_new.kind = (slot_ok && cmd_new.period != '0) ? KIND_START : KIND_REJECT;
      OP_STOP:  cmd_new.kind = slot_ok ? KIND_STOP : KIND_REJECT;
      default:  cmd_new.kind = KIND_REJECT;
    endcase
  end

  assign s_ready_o   = count_q != QFULL;
  assign cmd_valid_o = count_q != '0;
  assign cmd_o       = q_mem[rd_ptr_q];
  assign push        = s_valid_i && s_ready_o;
  assign pop         = cmd_valid_o && cmd_ready_i;

  always_comb begin
    case ({push, pop})
      2'b10:   count_d = count_q + 1'b1;
      2'b01:   count_d = count_q - 1'b1;
      default: count_d = count_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (push) begin
      q_mem[wr_ptr_q] <= cmd_new;
    end
  end

endmodule

FILE: src/pmt_div.sv
// ----------------------------------------------------------------------------
// Timer bank constant divider
// Pipelined restoring division by a fixed divisor, several quotient bits per
// stage, with the quotient saturated to the time width.
// ----------------------------------------------------------------------------
module pmt_div
  import pmt_pkg::*;
#(
  parameter int unsigned DIVISOR = 80,
  parameter int unsigned NUM_W   = 50,
  parameter int unsigned TAG_W   = 5
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic [NUM_W-1:0]  in_num_i,
  input  logic [TAG_W-1:0]  in_tag_i,
  output logic              out_valid_o,
  output logic [TAG_W-1:0]  out_tag_o,
  output logic [TIME_W-1:0] out_quot_o
);

  localparam int unsigned NS  = (NUM_W + DIV_STEP - 1) / DIV_STEP;
  localparam int unsigned DPW = NS * DIV_STEP;
  localparam int unsigned RMW = $clog2(DIVISOR + 1);
  localparam logic [RMW:0] DIV_C = (RMW + 1)'(DIVISOR);

  logic [NS-1:0]    valid_q;
  logic [TAG_W-1:0] tag_q  [NS];
  logic [RMW-1:0]   rem_q  [NS];
  logic [DPW-1:0]   work_q [NS];
  logic [RMW-1:0]   r_in   [NS];
  logic [DPW-1:0]   w_in   [NS];
  logic [RMW-1:0]   r_nx   [NS];
  logic [DPW-1:0]   w_nx   [NS];
  logic [DPW-1:0]   quot;

  function automatic logic [RMW+DPW-1:0] div_step(logic [RMW-1:0] rem, logic [DPW-1:0] work);
    logic [RMW:0]   t;
    logic [RMW-1:0] r;
    logic [DPW-1:0] w;
    logic           qb;
    r = rem;
    w = work;
    for (int k = 0; k < DIV_STEP; k++) begin
      t  = {r, w[DPW-1]};
      qb = t >= DIV_C;
      if (qb) begin
        t = t - DIV_C;
      end
      r = t[RMW-1:0];
      w = {w[DPW-2:0], qb};
    end
    return {r, w};
  endfunction

  always_comb begin
    r_in[0] = '0;
    w_in[0] = DPW'(in_num_i);
    for (int s = 1; s < NS; s++) begin
      r_in[s] = rem_q[s-1];
      w_in[s] = work_q[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      {r_nx[s], w_nx[s]} = div_step(r_in[s], w_in[s]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= NS'({valid_q, in_valid_i});
    end
  end

  always_ff @(posedge clk_i) begin
    tag_q[0] <= in_tag_i;
    for (int s = 1; s < NS; s++) begin
      tag_q[s] <= tag_q[s-1];
    end
    for (int s = 0; s < NS; s++) begin
      rem_q[s]  <= r_nx[s];
      work_q[s] <= w_nx[s];
    end
  end

  assign quot        = work_q[NS-1];
  assign out_valid_o = valid_q[NS-1];
  assign out_tag_o   = tag_q[NS-1];
  assign out_quot_o  = (|quot[DPW-1:TIME_W]) ? '1 : quot[TIME_W-1:0];

endmodule

FILE: src/pmt_back.sv
// ----------------------------------------------------------------------------
// Timer bank back end
// Holds the per-slot timer state, carries out start and stop commands, and
// sweeps all slots through the elapsed-time pipeline on a poll.
// ----------------------------------------------------------------------------
module pmt_back
  import pmt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS    = 8,
  parameter int unsigned RELOAD_VALUE  = 79999,
  parameter int unsigned COUNTS_PER_US = 80
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  cmd_valid_i,
  output logic                  cmd_ready_o,
  input  cmd_t                  cmd_i,
  output logic                  m_valid_o,
  input  logic                  m_ready_i,
  output logic [OUT_DATA_W-1:0] m_data_o
);

  localparam int unsigned IW = (NUM_TIMERS > 1) ? $clog2(NUM_TIMERS) : 1;
  localparam int unsigned RW = $clog2(RELOAD_VALUE + 2);
  localparam int unsigned PW = TIME_W + RW;
  localparam int unsigned NW = ((PW > CNT_W) ? PW : CNT_W) + 1;
  localparam int unsigned XW = NW + 1;
  localparam logic [RW-1:0] RELOAD_P1 = RW'(RELOAD_VALUE + 1);
  localparam logic [IW-1:0] LAST_IDX = IW'(NUM_TIMERS - 1);

  typedef struct packed {
    logic [IW-1:0] idx;
    logic          en;
    logic          last;
  } tag_t;

  localparam int unsigned TAG_W = $bits(tag_t);

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_ISSUE = 3'b010,
    ST_DRAIN = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [NUM_TIMERS-1:0] enabled_q;
  logic [TIME_W-1:0]     period_q   [NUM_TIMERS];
  logic [TIME_W-1:0]     acc_q      [NUM_TIMERS];
  logic [TIME_W-1:0]     last_ms_q  [NUM_TIMERS];
  logic [CNT_W-1:0]      last_cnt_q [NUM_TIMERS];

  logic [IW-1:0]     idx_q;
  logic [TIME_W-1:0] now_ms_q;
  logic [CNT_W-1:0]  now_cnt_q;
  logic [MASK_W-1:0] fire_q;

  logic              out_free, pop, do_poll, do_start, do_stop;
  logic [IW-1:0]     slot_idx;
  logic              issue_valid;
  tag_t              issue_tag;

  logic              p1_valid_q, p2_valid_q, p3_valid_q, a_valid_q;
  tag_t              p1_tag_q, p2_tag_q, p3_tag_q, a_tag_q;
  logic [TIME_W-1:0] p1_diff_q;
  logic [CNT_W-1:0]  p1_lc_q, p2_lc_q;
  logic [PW-1:0]     p2_prod_q;
  logic [NW-1:0]     p3_num_q, num_d;
  logic [XW-1:0]     wide, wide_diff;

  logic              dv_valid;
  logic [TAG_W-1:0]  dv_tag_raw;
  tag_t              dv_tag;
  logic [TIME_W-1:0] dv_quot;
  logic [TIME_W:0]   sum_ext;
  logic [TIME_W-1:0] a_sum_q, a_sum_d;

  logic              b_ge, wb_en, poll_done;
  logic [TIME_W-1:0] b_acc, b_period;
  logic [MASK_W-1:0] fire_now;

  logic              res_load, res_acc;
  logic [MASK_W-1:0] res_fire;
  logic              m_valid_q, m_acc_q;
  logic [MASK_W-1:0] m_fire_q;

  assign out_free    = !m_valid_q || m_ready_i;
  assign cmd_ready_o = (state_q == ST_IDLE) && out_free;
  assign pop         = cmd_valid_i && cmd_ready_o;
  assign do_poll     = pop && cmd_i.kind == KIND_POLL;
  assign do_start    = pop && cmd_i.kind == KIND_START;
  assign do_stop     = pop && cmd_i.kind == KIND_STOP;
  assign slot_idx    = IW'(cmd_i.slot);

  assign issue_valid   = state_q == ST_ISSUE;
  assign issue_tag.idx = idx_q;
  assign issue_tag.en  = enabled_q[idx_q];
  assign issue_tag.last = idx_q == LAST_IDX;

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (do_poll) begin
          state_d = ST_ISSUE;
        end
      end
      ST_ISSUE: begin
        if (idx_q == LAST_IDX) begin
          state_d = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        if (poll_done) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      fire_q  <= '0;
    end else begin
      state_q <= state_d;
      if (do_poll) begin
        idx_q  <= '0;
        fire_q <= '0;
      end else begin
        if (issue_valid) begin
          idx_q <= idx_q + 1'b1;
        end
        if (a_valid_q) begin
          fire_q <= fire_q | fire_now;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_poll) begin
      now_ms_q  <= cmd_i.ms;
      now_cnt_q <= cmd_i.cnt;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enabled_q <= '0;
      for (int i = 0; i < NUM_TIMERS; i++) begin
        period_q[i] <= '0;
        acc_q[i]    <= '0;
      end
    end else begin
      if (do_start) begin
        enabled_q[slot_idx] <= 1'b1;
        period_q[slot_idx]  <= cmd_i.period;
        acc_q[slot_idx]     <= '0;
      end
      if (do_stop) begin
        enabled_q[slot_idx] <= 1'b0;
        acc_q[slot_idx]     <= '0;
      end
      if (wb_en) begin
        acc_q[a_tag_q.idx] <= b_acc;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_start) begin
      last_ms_q[slot_idx]  <= cmd_i.ms;
      last_cnt_q[slot_idx] <= cmd_i.cnt;
    end
    if (issue_valid && issue_tag.en) begin
      last_ms_q[idx_q]  <= now_ms_q;
      last_cnt_q[idx_q] <= now_cnt_q;
    end
  end

  // Elapsed-time pipeline: tick difference, scale to counts, numerator.
  always_comb begin
    wide      = XW'(p2_prod_q) + XW'(p2_lc_q);
    wide_diff = wide - XW'(now_cnt_q);
    num_d     = (wide < XW'(now_cnt_q)) ? '0 : wide_diff[NW-1:0];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p1_valid_q <= 1'b0;
      p2_valid_q <= 1'b0;
      p3_valid_q <= 1'b0;
      a_valid_q  <= 1'b0;
    end else begin
      p1_valid_q <= issue_valid;
      p2_valid_q <= p1_valid_q;
      p3_valid_q <= p2_valid_q;
      a_valid_q  <= dv_valid;
    end
  end

  always_ff @(posedge clk_i) begin
    p1_tag_q  <= issue_tag;
    p1_diff_q <= now_ms_q - last_ms_q[idx_q];
    p1_lc_q   <= last_cnt_q[idx_q];
    p2_tag_q  <= p1_tag_q;
    p2_prod_q <= PW'(p1_diff_q) * PW'(RELOAD_P1);
    p2_lc_q   <= p1_lc_q;
    p3_tag_q  <= p2_tag_q;
    p3_num_q  <= num_d;
    a_tag_q   <= dv_tag;
    a_sum_q   <= a_sum_d;
  end

  pmt_div #(
    .DIVISOR (COUNTS_PER_US),
    .NUM_W   (NW),
    .TAG_W   (TAG_W)
  ) u_div (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (p3_valid_q),
    .in_num_i    (p3_num_q),
    .in_tag_i    (p3_tag_q),
    .out_valid_o (dv_valid),
    .out_tag_o   (dv_tag_raw),
    .out_quot_o  (dv_quot)
  );

  assign dv_tag  = tag_t'(dv_tag_raw);
  assign sum_ext = {1'b0, acc_q[dv_tag.idx]} + {1'b0, dv_quot};
  assign a_sum_d = sum_ext[TIME_W] ? '1 : sum_ext[TIME_W-1:0];

  // Period check and writeback.
  always_comb begin
    b_period = period_q[a_tag_q.idx];
    b_ge     = a_sum_q >= b_period;
    b_acc    = b_ge ? a_sum_q - b_period : a_sum_q;
    wb_en    = a_valid_q && a_tag_q.en;
    fire_now = '0;
    for (int b = 0; b < MASK_W; b++) begin
      if (b < NUM_TIMERS && int'(a_tag_q.idx) == b) begin
        fire_now[b] = wb_en && b_ge;
      end
    end
  end

  assign poll_done = a_valid_q && a_tag_q.last;

  always_comb begin
    res_load = poll_done || (pop && cmd_i.kind != KIND_POLL);
    res_acc  = poll_done || cmd_i.kind != KIND_REJECT;
    res_fire = poll_done ? (fire_q | fire_now) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else begin
      m_valid_q <= res_load || (m_valid_q && !m_ready_i);
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_load) begin
      m_fire_q <= res_fire;
      m_acc_q  <= res_acc;
    end
  end

  assign m_valid_o = m_valid_q;
  assign m_data_o  = {{(OUT_DATA_W - OUT_BITS){1'b0}}, m_acc_q, m_fire_q};

`ifndef ASSERT_OFF
  a_idle_pipe_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_IDLE |-> !(p1_valid_q || p2_valid_q || p3_valid_q || a_valid_q))
    else $error("Elapsed-time pipeline active while idle.");

  a_done_in_drain: assert property (@(posedge clk_i) disable iff (!rst_ni)
    poll_done |-> state_q == ST_DRAIN)
    else $error("Last slot written back outside the drain phase.");

  a_div_in_poll: assert property (@(posedge clk_i) disable iff (!rst_ni)
    dv_valid |-> (state_q == ST_ISSUE || state_q == ST_DRAIN))
    else $error("Divider output outside a poll.");

  a_reject_no_fire: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_valid_q && !m_acc_q) |-> m_fire_q == '0)
    else $error("Rejected operation reports fired timers.");
`endif

endmodule

FILE: src/periodic_microsecond_timer_bank.sv
// ----------------------------------------------------------------------------
// Periodic microsecond timer bank
// Bank of periodic timers driven by a millisecond tick and a down-counting
// sub-millisecond counter; start, stop and poll operations give a fire mask.
// ----------------------------------------------------------------------------
// Each input transfer carries one operation together with the current tick
// and counter values; each one produces exactly one output transfer holding
// the fire mask and the accepted flag, in order.
// Start, stop and rejected operations have their result registered as the
// back end takes them from the queue. A poll sweeps the slots one per cycle
// through a pipeline of tick difference, counter scaling, a divider by
// COUNTS_PER_US of NS = ceil(W/8) stages (W is the numerator width, 50 bits
// by default) and an accumulate-and-compare writeback; its result is
// registered once the last slot is written back. The back end takes one
// operation at a time, so a poll occupies it until that last writeback,
// while other operations are taken without leaving the idle state.
// A two-entry queue lets the input side keep accepting while the back end
// works, and the output register holds a result until it is taken; when
// the receiver stalls, the back end waits and the queue then fills.
// Reset disables all slots and clears periods and accumulators; the time
// snapshots are written by start before any result depends on them.
// ----------------------------------------------------------------------------
module periodic_microsecond_timer_bank
  import pmt_pkg::*;
#(
  parameter int unsigned NUM_TIMERS    = 8,
  parameter int unsigned RELOAD_VALUE  = 79999,
  parameter int unsigned COUNTS_PER_US = 80
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // operation[1:0], slot[4:2], period[36:5], ms_tick[68:37], counter_value[85:69]
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // fire_mask[7:0], accepted[8]
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  logic cmd_valid, cmd_ready;
  cmd_t cmd;

  pmt_front #(
    .NUM_TIMERS (NUM_TIMERS)
  ) u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .s_valid_i   (s_axis_tvalid),
    .s_ready_o   (s_axis_tready),
    .s_data_i    (s_axis_tdata),
    .cmd_valid_o (cmd_valid),
    .cmd_ready_i (cmd_ready),
    .cmd_o       (cmd)
  );

  pmt_back #(
    .NUM_TIMERS    (NUM_TIMERS),
    .RELOAD_VALUE  (RELOAD_VALUE),
    .COUNTS_PER_US (COUNTS_PER_US)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_valid_i (cmd_valid),
    .cmd_ready_o (cmd_ready),
    .cmd_i       (cmd),
    .m_valid_o   (m_axis_tvalid),
    .m_ready_i   (m_axis_tready),
    .m_data_o    (m_axis_tdata)
  );

endmodule

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// Periodic microsecond timer bank testbench
// Sends start, stop and poll operations with a running millisecond tick and
// sub-millisecond counter: first a table of directed cases, then random
// traffic along a consistent timeline mixed with out-of-order times. Each
// output transfer is checked against a table entry or a local bank model.
// ----------------------------------------------------------------------------
module tb;
  import pmt_pkg::*;

  localparam int unsigned NUM_SLOTS     = 8;
  localparam int unsigned COUNTS_PER_MS = 80000;
  localparam int unsigned COUNTS_PER_US = 80;
  localparam int unsigned RANDOM_ITEMS  = 1650;
  localparam int unsigned IDLE_LIMIT    = 5000;
  localparam int unsigned DRAIN_CYCLES  = 30;
  localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [SLOT_W-1:0] slot;
    logic [TIME_W-1:0] period;
    logic [TIME_W-1:0] ms;
    logic [CNT_W-1:0]  cnt;
  } timer_cmd_t;

  typedef struct packed {
    logic [MASK_W-1:0] fire_mask;
    logic              accepted;
  } fire_result_t;

  typedef struct packed {
    timer_cmd_t   cmd;
    logic         typed;
    fire_result_t want;
  } directed_row_t;

  logic                  clk_i = 1'b0;
  logic                  rst_ni = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  bit                    slot_armed    [NUM_SLOTS];
  bit [TIME_W-1:0]       slot_period   [NUM_SLOTS];
  bit [TIME_W-1:0]       slot_accum_us [NUM_SLOTS];
  bit [TIME_W-1:0]       slot_ms_snap  [NUM_SLOTS];
  bit [CNT_W-1:0]        slot_cnt_snap [NUM_SLOTS];

  fire_result_t          pending_fires [$];
  int unsigned           fail_count = 0;
  int unsigned           idle_cycles = 0;
  int unsigned           rx_cycle = 0;
  int unsigned           burst_left = 0;
  longint unsigned       timeline = 64'(32'hFFFF_F000) * COUNTS_PER_MS;

  directed_row_t directed_rows [0:20] = '{
    '{'{OP_POLL,   3'd0, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b1}},
    '{'{OP_UNUSED, 3'd7, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 17'h1FFFF}, 1'b1, '{8'h00, 1'b0}},
    '{'{OP_START,  3'd0, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b0}},
    '{'{OP_STOP,   3'd5, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b1}},
    '{'{OP_START,  3'd0, 32'd1,         32'h0,         17'd79999}, 1'b1, '{8'h00, 1'b1}},
    '{'{OP_START,  3'd7, 32'hFFFF_FFFF, 32'h0,         17'd79999}, 1'b1, '{8'h00, 1'b1}},
    '{'{OP_START,  3'd3, 32'd1000,      32'd10,        17'd40000}, 1'b1, '{8'h00, 1'b1}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'd1,         17'd79999}, 1'b0, '{8'h00, 1'b0}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'd1,         17'd80000}, 1'b0, '{8'h00, 1'b0}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'd1,         17'h1FFFF}, 1'b0, '{8'h00, 1'b0}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'hFFFF_FFFF, 17'd0},     1'b0, '{8'h00, 1'b0}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'h0,         17'd79999}, 1'b0, '{8'h00, 1'b0}},
    '{'{OP_STOP,   3'd3, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b1}},
    '{'{OP_START,  3'd3, 32'h8000_0000, 32'h1234_5678, 17'h0ABCD}, 1'b1, '{8'h00, 1'b1}},
    '{'{OP_START,  3'd5, 32'h5555_5555, 32'h0,         17'd40000}, 1'b1, '{8'h00, 1'b1}},
    '{'{OP_START,  3'd6, 32'd2,         32'h0,         17'd79999}, 1'b1, '{8'h00, 1'b1}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'd2,         17'd0},     1'b0, '{8'h00, 1'b0}},
    '{'{OP_UNUSED, 3'd0, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b0}},
    '{'{OP_STOP,   3'd0, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b1}},
    '{'{OP_POLL,   3'd0, 32'h0,         32'd3,         17'd79999}, 1'b0, '{8'h00, 1'b0}},
    '{'{OP_START,  3'd4, 32'h0,         32'h0,         17'd0},     1'b1, '{8'h00, 1'b0}}
  };

  periodic_microsecond_timer_bank uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always #5 clk_i = ~clk_i;

  function automatic bit [TIME_W-1:0] microseconds_since(int s, bit [TIME_W-1:0] now_ms,
                                                         bit [CNT_W-1:0] now_cnt);
    bit [TIME_W-1:0] ms_diff;
    bit [63:0]       numer;
    bit [63:0]       quot;
    ms_diff = now_ms - slot_ms_snap[s];
    numer = 64'(ms_diff) * 64'(COUNTS_PER_MS) + 64'(slot_cnt_snap[s]);
    if (numer < 64'(now_cnt)) return '0;
    quot = (numer - 64'(now_cnt)) / 64'(COUNTS_PER_US);
    return (quot > 64'hFFFF_FFFF) ? '1 : quot[TIME_W-1:0];
  endfunction

  function automatic fire_result_t step_timer_bank(timer_cmd_t c);
    fire_result_t    res;
    bit [TIME_W:0]   sum;
    res = '0;
    case (c.op)
      OP_POLL: begin
        res.accepted = 1'b1;
        for (int i = 0; i < NUM_SLOTS; i++) begin
          if (slot_armed[i]) begin
            sum = {1'b0, slot_accum_us[i]} + {1'b0, microseconds_since(i, c.ms, c.cnt)};
            slot_accum_us[i] = sum[TIME_W] ? '1 : sum[TIME_W-1:0];
            slot_ms_snap[i] = c.ms;
            slot_cnt_snap[i] = c.cnt;
            if (slot_accum_us[i] >= slot_period[i]) begin
              slot_accum_us[i] -= slot_period[i];
              res.fire_mask[i] = 1'b1;
            end
          end
        end
      end
      OP_START: begin
        if (c.period != '0) begin
          slot_armed[c.slot] = 1'b1;
          slot_period[c.slot] = c.period;
          slot_accum_us[c.slot] = '0;
          slot_ms_snap[c.slot] = c.ms;
          slot_cnt_snap[c.slot] = c.cnt;
          res.accepted = 1'b1;
        end
      end
      OP_STOP: begin
        slot_armed[c.slot] = 1'b0;
        slot_accum_us[c.slot] = '0;
        res.accepted = 1'b1;
      end
      default: begin
      end
    endcase
    return res;
  endfunction

  function automatic timer_cmd_t random_timer_cmd();
    timer_cmd_t  c;
    int unsigned pick;
    int unsigned dt_us;
    pick = $urandom_range(0, 99);
    dt_us = (pick < 60) ? $urandom_range(0, 800) :
            (pick < 90) ? $urandom_range(0, 20000) : $urandom_range(0, 3000000);
    timeline += 64'(dt_us) * COUNTS_PER_US + $urandom_range(0, COUNTS_PER_US - 1);
    c.ms = TIME_W'(timeline / COUNTS_PER_MS);
    c.cnt = CNT_W'(COUNTS_PER_MS - 1 - (timeline % COUNTS_PER_MS));
    pick = $urandom_range(0, 99);
    c.op = (pick < 55) ? OP_POLL : (pick < 80) ? OP_START : (pick < 93) ? OP_STOP : OP_UNUSED;
    c.slot = SLOT_W'($urandom_range(0, NUM_SLOTS - 1));
    pick = $urandom_range(0, 99);
    c.period = (pick < 5) ? '0 : (pick < 75) ? $urandom_range(1, 5000) :
               (pick < 90) ? $urandom_range(1, 200000) : $urandom;
    if ($urandom_range(0, 99) < 8) begin
      c.ms = $urandom;
      c.cnt = CNT_W'($urandom_range(0, (1 << CNT_W) - 1));
    end
    return c;
  endfunction

  task automatic pace_sender();
    int unsigned gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = ($urandom_range(0, 9) == 0) ? 60 : $urandom_range(1, 16);
    end
    burst_left--;
  endtask

  task automatic send_timer_cmd(timer_cmd_t c, logic typed, fire_result_t want);
    logic [IN_DATA_W-1:0] word;
    fire_result_t         predicted;
    word = '0;
    word[IN_OP_LSB +: OP_W] = c.op;
    word[IN_SLOT_LSB +: SLOT_W] = c.slot;
    word[IN_PERIOD_LSB +: TIME_W] = c.period;
    word[IN_MS_LSB +: TIME_W] = c.ms;
    word[IN_CNT_LSB +: CNT_W] = c.cnt;
    pace_sender();
    s_axis_tdata <= word;
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = step_timer_bank(c);
    pending_fires.push_back(typed ? want : predicted);
  endtask

  always @(posedge clk_i) begin
    fire_result_t got;
    fire_result_t want;
    int unsigned  mode;
    rx_cycle <= rx_cycle + 1;
    mode = (rx_cycle / 400) % 4;
    case (mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= 1'($urandom_range(0, 1));
      2: m_axis_tready <= (rx_cycle % 5) == 0;
      default: m_axis_tready <= (rx_cycle % 40) >= 12;
    endcase
    if (m_axis_tvalid && m_axis_tready) begin
      got.fire_mask = m_axis_tdata[MASK_W-1:0];
      got.accepted = m_axis_tdata[MASK_W];
      if (pending_fires.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual %03h", $time, got);
        fail_count++;
      end else begin
        want = pending_fires.pop_front();
        if (got.fire_mask !== want.fire_mask) begin
          $display("%0t: fire_mask mismatch, expected %02h, actual %02h",
                   $time, want.fire_mask, got.fire_mask);
          fail_count++;
        end
        if (got.accepted !== want.accepted) begin
          $display("%0t: accepted mismatch, expected %0b, actual %0b",
                   $time, want.accepted, got.accepted);
          fail_count++;
        end
      end
    end
  end

  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (directed_rows[r]) begin
      send_timer_cmd(directed_rows[r].cmd, directed_rows[r].typed, directed_rows[r].want);
    end
    s_axis_tvalid <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (RANDOM_ITEMS) send_timer_cmd(random_timer_cmd(), 1'b0, '0);
    s_axis_tvalid <= 1'b0;
    while (pending_fires.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
